[src/salc_pkg.sv]
package salc_pkg;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int FUNC_W     = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_CNT_W  = 32;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_WAYS         = 8;
    localparam int DEF_COUNT_WIDTH  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_STORE  = 2'd1,
        FUNC_MODIFY = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS_USED  = 2'd2;

    localparam logic [2:0] SET_BITS_RST   = 3'd1;
    localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [3:0] WAYS_USED_RST  = 4'd8;

    typedef struct packed {
        logic       was_miss;
        logic       was_eviction;
        logic [1:0] hits_added;
    } flags_t;

    // rank field width per line
    function automatic int rank_width(input int ways);
        return (ways > 1) ? $clog2(ways) : 1;
    endfunction

    // width of a line count 0..ways
    function automatic int cnt_width(input int ways);
        return $clog2(ways + 1);
    endfunction

    // one set row: valid bits, ranks, tags
    function automatic int row_width(input int ways);
        return ways * (1 + rank_width(ways) + TAG_W);
    endfunction

endpackage

[src/salc_row_mem.sv]
module salc_row_mem #(
    parameter int ADDR_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int DATA_W    = salc_pkg::row_width(salc_pkg::DEF_WAYS)
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_W-1:0]    rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_W-1:0]    wr_data
);

    logic [DATA_W-1:0] row_mem [2**ADDR_BITS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/salc_row_update.sv]
module salc_row_update #(
    parameter int WAYS = salc_pkg::DEF_WAYS
) (
    input  logic [salc_pkg::row_width(WAYS)-1:0] row_in,
    input  logic [salc_pkg::TAG_W-1:0]           tag,
    input  logic [salc_pkg::FUNC_W-1:0]          func,
    input  logic [salc_pkg::cnt_width(WAYS)-1:0] ways,
    output logic [salc_pkg::row_width(WAYS)-1:0] row_out,
    output logic                                 write_en,
    output salc_pkg::flags_t                     flags
);

    import salc_pkg::*;

    localparam int RANK_W = rank_width(WAYS);
    localparam int CNT_W  = cnt_width(WAYS);
    localparam int TAG_LO = WAYS * (1 + RANK_W);

    logic [WAYS-1:0]   valid;
    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   hit_oh;
    logic [WAYS-1:0]   free_oh;
    logic [WAYS-1:0]   victim_oh;
    logic [WAYS-1:0]   target_oh;
    logic [WAYS-1:0]   inc_vec;
    logic [RANK_W-1:0] rank [WAYS];
    logic [RANK_W-1:0] new_rank [WAYS];
    logic [TAG_W-1:0]  tags [WAYS];
    logic [CNT_W-1:0]  count;
    logic [RANK_W-1:0] last_rank;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] target_rank;
    logic              hit;
    logic              full;
    logic              fill;
    logic              active;
    logic              modify;

    always_comb
    begin
        count    = '0;
        hit_rank = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            valid[w]   = row_in[w];
            rank[w]    = row_in[WAYS + w*RANK_W +: RANK_W];
            tags[w]    = row_in[TAG_LO + w*TAG_W +: TAG_W];
            hit_vec[w] = valid[w] && (tags[w] == tag);
            count      = count + CNT_W'(valid[w]);
        end

        // lowest matching way, lowest empty way
        hit_oh  = hit_vec & (~hit_vec + WAYS'(1));
        free_oh = ~valid & (valid + WAYS'(1));
        hit     = |hit_vec;

        // ranks of valid lines are a permutation of 0..count-1
        last_rank = RANK_W'(count - CNT_W'(1));
        for (int w = 0; w < WAYS; w++)
        begin
            victim_oh[w] = valid[w] && (rank[w] == last_rank);
            hit_rank     = hit_rank | (hit_oh[w] ? rank[w] : '0);
        end

        full        = (count >= ways) || (free_oh == '0);
        fill        = !hit && !full;
        target_oh   = hit ? hit_oh : (full ? victim_oh : free_oh);
        target_rank = hit ? hit_rank : last_rank;
        active      = (func != FUNC_NONE);
        modify      = (func == FUNC_MODIFY);

        for (int w = 0; w < WAYS; w++)
        begin
            inc_vec[w]  = valid[w] && !target_oh[w] && (fill || (rank[w] < target_rank));
            new_rank[w] = target_oh[w] ? '0 :
                          (inc_vec[w] ? rank[w] + RANK_W'(1) : rank[w]);
            row_out[w]  = valid[w] | target_oh[w];
            row_out[WAYS + w*RANK_W +: RANK_W] = new_rank[w];
            row_out[TAG_LO + w*TAG_W +: TAG_W] = (!hit && target_oh[w]) ? tag : tags[w];
        end

        write_en           = active;
        flags.was_miss     = active && !hit;
        flags.was_eviction = active && !hit && full;
        if (!active)
        begin
            flags.hits_added = 2'd0;
        end
        else if (hit)
        begin
            flags.hits_added = modify ? 2'd2 : 2'd1;
        end
        else
        begin
            flags.hits_added = modify ? 2'd1 : 2'd0;
        end
    end

endmodule

[src/salc_stats.sv]
module salc_stats #(
    parameter int COUNT_WIDTH = salc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  salc_pkg::flags_t                  flags,
    input  logic                              out_ready,
    output logic                              out_free,
    output logic                              out_valid,
    output logic                              was_miss,
    output logic                              was_eviction,
    output logic [1:0]                        hits_added,
    output logic [salc_pkg::OUT_CNT_W-1:0]    total_hits,
    output logic [salc_pkg::OUT_CNT_W-1:0]    total_misses,
    output logic [salc_pkg::OUT_CNT_W-1:0]    total_evictions
);

    import salc_pkg::*;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    flags_t                 flags_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_next;
    logic [COUNT_WIDTH-1:0] miss_cnt_reg;
    logic [COUNT_WIDTH-1:0] miss_cnt_next;
    logic [COUNT_WIDTH-1:0] evict_cnt_reg;
    logic [COUNT_WIDTH-1:0] evict_cnt_next;
    logic [COUNT_WIDTH:0]   hit_sum;
    logic [COUNT_WIDTH:0]   miss_sum;
    logic [COUNT_WIDTH:0]   evict_sum;

    assign out_free = !out_valid_reg || out_ready;

    // saturate on carry out
    always_comb
    begin
        hit_sum        = {1'b0, hit_cnt_reg} + (COUNT_WIDTH+1)'(flags.hits_added);
        miss_sum       = {1'b0, miss_cnt_reg} + (COUNT_WIDTH+1)'(flags.was_miss);
        evict_sum      = {1'b0, evict_cnt_reg} + (COUNT_WIDTH+1)'(flags.was_eviction);
        hit_cnt_next   = hit_sum[COUNT_WIDTH] ? '1 : hit_sum[COUNT_WIDTH-1:0];
        miss_cnt_next  = miss_sum[COUNT_WIDTH] ? '1 : miss_sum[COUNT_WIDTH-1:0];
        evict_cnt_next = evict_sum[COUNT_WIDTH] ? '1 : evict_sum[COUNT_WIDTH-1:0];
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags;
        end
    end

    assign out_valid       = out_valid_reg;
    assign was_miss        = flags_reg.was_miss;
    assign was_eviction    = flags_reg.was_eviction;
    assign hits_added      = flags_reg.hits_added;
    assign total_hits      = OUT_CNT_W'(hit_cnt_reg);
    assign total_misses    = OUT_CNT_W'(miss_cnt_reg);
    assign total_evictions = OUT_CNT_W'(evict_cnt_reg);

endmodule

[src/set_assoc_lru_cache_model.sv]
// Set-associative cache model with LRU replacement that scores hits, misses
// and evictions for a stream of data accesses (load, store, modify). Each set
// lives in one row of a synchronous memory: per way a valid bit, a recency rank
// (0 = most recent) and a 64-bit tag. In the transfer cycle the set index is
// cut out of the address and the set row is read; in the lookup state that
// follows, the row is compared, updated and written back, and the result is
// loaded into the output register. That read-modify-write of one row means a
// new access is taken only after the lookup of the last one is done, and the
// lookup state holds while a previous result still waits. The next access is
// taken while a result waits in the output register. After reset a clearing
// pass writes all 2**MAX_SET_BITS rows to empty (64 with the defaults), one
// row per cycle; in_ready stays low until it is done, while register
// writes are taken as usual. Registers on the APB port: set_bits at 0x0,
// block_bits at 0x4, ways_used at 0x8. A set_bits above MAX_SET_BITS acts as
// MAX_SET_BITS, a ways_used of 0 acts as 1 and above WAYS as WAYS. Func code 3
// leaves all state alone and reports zero flags with the running totals.
// Totals saturate at 2**COUNT_WIDTH-1 and show their low 32 bits.
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int WAYS         = salc_pkg::DEF_WAYS,
    parameter int COUNT_WIDTH  = salc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // access channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [salc_pkg::FUNC_W-1:0]       func,
    input  logic [salc_pkg::ADDR_W-1:0]       address,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              was_miss,
    output logic                              was_eviction,
    output logic [1:0]                        hits_added,
    output logic [salc_pkg::OUT_CNT_W-1:0]    total_hits,
    output logic [salc_pkg::OUT_CNT_W-1:0]    total_misses,
    output logic [salc_pkg::OUT_CNT_W-1:0]    total_evictions,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [salc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [salc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    import salc_pkg::*;

    localparam int SET_W  = MAX_SET_BITS;
    localparam int ROW_W  = row_width(WAYS);
    localparam int CNT_W  = cnt_width(WAYS);
    localparam int SH_W   = 7;   // holds MAX_SET_BITS + 63

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SET_W-1:0]      clr_idx_reg;
    logic [SET_W-1:0]      clr_idx_next;
    logic [SET_W-1:0]      set_idx_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [FUNC_W-1:0]     func_reg;

    // configuration registers
    logic [2:0]            set_bits_reg;
    logic [5:0]            block_bits_reg;
    logic [3:0]            ways_used_reg;
    logic                  cfg_write;

    // address split
    logic [SH_W-1:0]       set_bits_eff;
    logic [SH_W-1:0]       tag_shift;
    logic [ADDR_W-1:0]     addr_shifted;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_idx;
    logic [TAG_W-1:0]      tag;
    logic [CNT_W-1:0]      ways_eff;

    // memory ports
    logic                  in_xfer;
    logic                  mem_wr_en;
    logic [SET_W-1:0]      mem_wr_addr;
    logic [ROW_W-1:0]      mem_wr_data;
    logic [ROW_W-1:0]      mem_rd_data;

    // update and result
    logic [ROW_W-1:0]      row_new;
    logic                  upd_write;
    flags_t                upd_flags;
    logic                  out_free;
    logic                  stat_load;

    //------------------------------------------------------------------
    // register port: always ready, writes decode on the word address
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_used_reg  <= WAYS_USED_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_SET_BITS:   set_bits_reg   <= pwdata[2:0];
                REG_BLOCK_BITS: block_bits_reg <= pwdata[5:0];
                REG_WAYS_USED:  ways_used_reg  <= pwdata[3:0];
                default:        ;  // no register there
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SET_BITS:   prdata = CFG_DATA_W'(set_bits_reg);
            REG_BLOCK_BITS: prdata = CFG_DATA_W'(block_bits_reg);
            REG_WAYS_USED:  prdata = CFG_DATA_W'(ways_used_reg);
            default:        prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // address split: set index below the tag, tag is zero when the
    // shift reaches the full address width
    //------------------------------------------------------------------
    always_comb
    begin
        set_bits_eff = (32'(set_bits_reg) > MAX_SET_BITS) ? SH_W'(MAX_SET_BITS)
                                                          : SH_W'(set_bits_reg);
        tag_shift    = set_bits_eff + SH_W'(block_bits_reg);
        addr_shifted = address >> block_bits_reg;
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < 32'(set_bits_eff));
        end
        set_idx = addr_shifted[SET_W-1:0] & set_mask;
        tag     = tag_shift[SH_W-1] ? '0 : (address >> tag_shift[5:0]);

        if (ways_used_reg == 4'd0)
        begin
            ways_eff = CNT_W'(1);
        end
        else if (32'(ways_used_reg) > WAYS)
        begin
            ways_eff = CNT_W'(WAYS);
        end
        else
        begin
            ways_eff = CNT_W'(ways_used_reg);
        end
    end

    //------------------------------------------------------------------
    // control: clearing pass, then read in the transfer cycle and
    // write back in the lookup cycle
    //------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign stat_load = (state_reg == ST_LOOKUP) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // access payload captured at transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            set_idx_reg <= set_idx;
            tag_reg     <= tag;
            func_reg    <= func;
        end
    end

    // write port: empty rows during clearing, updated row after lookup
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_reg;
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = stat_load && upd_write;
            mem_wr_addr = set_idx_reg;
            mem_wr_data = row_new;
        end
    end

    salc_row_mem #(
        .ADDR_BITS (SET_W),
        .DATA_W    (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (set_idx),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    salc_row_update #(
        .WAYS (WAYS)
    ) u_row_update (
        .row_in   (mem_rd_data),
        .tag      (tag_reg),
        .func     (func_reg),
        .ways     (ways_eff),
        .row_out  (row_new),
        .write_en (upd_write),
        .flags    (upd_flags)
    );

    salc_stats #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (stat_load),
        .flags           (upd_flags),
        .out_ready       (out_ready),
        .out_free        (out_free),
        .out_valid       (out_valid),
        .was_miss        (was_miss),
        .was_eviction    (was_eviction),
        .hits_added      (hits_added),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions)
    );

    // an accepted access always goes to lookup next
    a_xfer_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_LOOKUP))
        else $error("access transfer not followed by lookup");

    // a result is loaded only when the output register is free
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        stat_load |-> (!out_valid || out_ready))
        else $error("result overwrote a pending transfer");

    // outside the clearing pass the memory is written only with a result
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && (state_reg != ST_CLEAR)) |-> stat_load)
        else $error("set row written without a result");

    // an eviction is always a miss
    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!was_eviction || was_miss))
        else $error("eviction reported on a hit");

endmodule

[dv/cache_access_checker.sv]
`timescale 1ns / 100ps

module cache_access_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [salc_pkg::FUNC_W-1:0]       func,
    input  logic [salc_pkg::ADDR_W-1:0]       address,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              was_miss,
    input  logic                              was_eviction,
    input  logic [1:0]                        hits_added,
    input  logic [salc_pkg::OUT_CNT_W-1:0]    total_hits,
    input  logic [salc_pkg::OUT_CNT_W-1:0]    total_misses,
    input  logic [salc_pkg::OUT_CNT_W-1:0]    total_evictions,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [salc_pkg::CFG_DATA_W-1:0]   pwdata,
    input  logic                              pready,
    output int                                check_errors,
    output int                                results_pending
);
    import salc_pkg::*;

    localparam int NSETS = 1 << DEF_MAX_SET_BITS;
    localparam int NWAYS = DEF_WAYS;
    localparam logic [63:0] COUNT_CEIL = (DEF_COUNT_WIDTH >= 64) ? '1 :
                                         ((64'd1 << DEF_COUNT_WIDTH) - 64'd1);

    typedef struct packed {
        flags_t      flags;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [31:0] evictions_total;
    } access_result_t;

    // shadow copy of the cache contents
    logic [63:0] line_tag  [NSETS][NWAYS];
    bit          line_live [NSETS][NWAYS];
    int          line_rank [NSETS][NWAYS];

    logic [2:0]  cfg_set_bits   = SET_BITS_RST;
    logic [5:0]  cfg_block_bits = BLOCK_BITS_RST;
    logic [3:0]  cfg_ways_used  = WAYS_USED_RST;
    logic [63:0] hit_count, miss_count, evict_count;

    access_result_t expected_access_q [$];

    function automatic logic [63:0] saturate_add(input logic [63:0] c, input int n);
        if (c > COUNT_CEIL)
            c = COUNT_CEIL;
        if (COUNT_CEIL - c < 64'(n))
            return COUNT_CEIL;
        return c + 64'(n);
    endfunction

    // lines more recent than the touched one age by one rank
    task automatic make_most_recent(input int s, input int w);
        int r, i;
        r = line_rank[s][w];
        for (i = 0; i < NWAYS; i++)
        begin
            if (line_live[s][i] && line_rank[s][i] < r)
                line_rank[s][i]++;
        end
        line_rank[s][w] = 0;
    endtask

    task automatic predict_cache_access(input func_t op, input logic [63:0] a);
        int sb, nways, shift, s, live_cnt, free_w, hit_w, victim, top_rank, w;
        int scored, missed, evicted;
        logic [63:0] tg;
        access_result_t res;
        scored  = 0;
        missed  = 0;
        evicted = 0;
        if (op != FUNC_NONE)
        begin
            sb = (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg_set_bits);
            nways = (cfg_ways_used == 0) ? 1 :
                    ((cfg_ways_used > NWAYS) ? NWAYS : int'(cfg_ways_used));
            shift = sb + int'(cfg_block_bits);
            tg = (shift >= 64) ? 64'd0 : (a >> shift);
            s = int'((a >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
            live_cnt = 0;
            free_w   = NWAYS;
            hit_w    = NWAYS;
            for (w = 0; w < NWAYS; w++)
            begin
                if (line_live[s][w])
                begin
                    live_cnt++;
                    if (hit_w == NWAYS && line_tag[s][w] == tg)
                        hit_w = w;
                end
                else if (free_w == NWAYS)
                    free_w = w;
            end
            if (hit_w != NWAYS)
            begin
                make_most_recent(s, hit_w);
                scored = (op == FUNC_MODIFY) ? 2 : 1;
            end
            else
            begin
                missed = 1;
                if (live_cnt >= nways || free_w == NWAYS)
                begin
                    // full set: the oldest live line goes, first one on a tie
                    victim   = -1;
                    top_rank = 0;
                    for (w = 0; w < NWAYS; w++)
                    begin
                        if (line_live[s][w] && (victim < 0 || line_rank[s][w] > top_rank))
                        begin
                            top_rank = line_rank[s][w];
                            victim   = w;
                        end
                    end
                    evicted = 1;
                    make_most_recent(s, victim);
                    line_tag[s][victim] = tg;
                end
                else
                begin
                    for (w = 0; w < NWAYS; w++)
                    begin
                        if (line_live[s][w])
                            line_rank[s][w]++;
                    end
                    line_live[s][free_w] = 1'b1;
                    line_rank[s][free_w] = 0;
                    line_tag[s][free_w]  = tg;
                end
                if (op == FUNC_MODIFY)
                    scored = 1;
            end
            hit_count   = saturate_add(hit_count, scored);
            miss_count  = saturate_add(miss_count, missed);
            evict_count = saturate_add(evict_count, evicted);
        end
        res.flags.was_miss     = missed[0];
        res.flags.was_eviction = evicted[0];
        res.flags.hits_added   = scored[1:0];
        res.hits_total         = hit_count[31:0];
        res.misses_total       = miss_count[31:0];
        res.evictions_total    = evict_count[31:0];
        expected_access_q.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            check_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        access_result_t want;
        int s, w;
        if (!rst_n)
        begin
            for (s = 0; s < NSETS; s++)
            begin
                for (w = 0; w < NWAYS; w++)
                begin
                    line_live[s][w] = 1'b0;
                    line_rank[s][w] = 0;
                end
            end
            hit_count      = '0;
            miss_count     = '0;
            evict_count    = '0;
            cfg_set_bits   = SET_BITS_RST;
            cfg_block_bits = BLOCK_BITS_RST;
            cfg_ways_used  = WAYS_USED_RST;
            expected_access_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SET_BITS:   cfg_set_bits   = pwdata[2:0];
                    REG_BLOCK_BITS: cfg_block_bits = pwdata[5:0];
                    REG_WAYS_USED:  cfg_ways_used  = pwdata[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_cache_access(func_t'(func), address);
            if (out_valid && out_ready)
            begin
                if (expected_access_q.size() == 0)
                begin
                    $error("result transfer with no access outstanding");
                    check_errors++;
                end
                else
                begin
                    want = expected_access_q.pop_front();
                    check_field("was_miss", 32'(want.flags.was_miss), 32'(was_miss));
                    check_field("was_eviction", 32'(want.flags.was_eviction),
                                32'(was_eviction));
                    check_field("hits_added", 32'(want.flags.hits_added), 32'(hits_added));
                    check_field("total_hits", want.hits_total, total_hits);
                    check_field("total_misses", want.misses_total, total_misses);
                    check_field("total_evictions", want.evictions_total, total_evictions);
                end
            end
        end
        results_pending = expected_access_q.size();
    end

endmodule

[dv/set_assoc_lru_cache_model_tb.sv]
`timescale 1ns / 100ps

module set_assoc_lru_cache_model_tb;
    import salc_pkg::*;

    localparam int NUM_PHASES         = 8;
    localparam int ACCESSES_PER_PHASE = 130;   // counted accesses, ignored ones excluded
    localparam int SETTLE_CYCLES      = 8;     // margin after the block drains
    localparam int CYCLE_LIMIT        = 500000;
    localparam int PAUSE_AT_ACCESS    = 400;   // sender waits for the pipe to empty here
    localparam int STALL_AT_RESULT    = 500;   // receiver blocks for a long stretch here
    localparam int STALL_HOLD_CYCLES  = 300;

    // register settings per phase; phase 0 runs on the reset values
    localparam logic [2:0] PHASE_SET_BITS [NUM_PHASES] =
        '{3'd1, 3'd3, 3'd0, 3'd6, 3'd7, 3'd2, 3'd6, 3'd1};
    localparam logic [5:0] PHASE_BLOCK_BITS [NUM_PHASES] =
        '{6'd4, 6'd6, 6'd0, 6'd32, 6'd63, 6'd1, 6'd12, 6'd4};
    localparam logic [3:0] PHASE_WAYS_USED [NUM_PHASES] =
        '{4'd8, 4'd4, 4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd8};

    logic                   clk     = 1'b0;
    logic                   rst_n   = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func    = '0;
    logic [ADDR_W-1:0]      address = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   was_miss;
    logic                   was_eviction;
    logic [1:0]             hits_added;
    logic [OUT_CNT_W-1:0]   total_hits;
    logic [OUT_CNT_W-1:0]   total_misses;
    logic [OUT_CNT_W-1:0]   total_evictions;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr   = '0;
    logic [CFG_DATA_W-1:0]  pwdata  = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int check_errors;
    int results_pending;
    int cycle_count    = 0;
    int accesses_sent  = 0;
    bit sender_calm    = 1'b0;

    // register values as last written, used to aim addresses at a few sets
    logic [2:0] cur_set_bits   = SET_BITS_RST;
    logic [5:0] cur_block_bits = BLOCK_BITS_RST;
    logic [3:0] cur_ways_used  = WAYS_USED_RST;

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    set_assoc_lru_cache_model DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .was_miss        (was_miss),
        .was_eviction    (was_eviction),
        .hits_added      (hits_added),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // prediction and comparison live in the checker
    cache_access_checker access_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .was_miss        (was_miss),
        .was_eviction    (was_eviction),
        .hits_added      (hits_added),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .check_errors    (check_errors),
        .results_pending (results_pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a few ignored codes mixed in with loads, stores and modifies
    function automatic func_t random_func();
        if ($urandom_range(0, 99) < 5)
            return FUNC_NONE;
        return func_t'($urandom_range(0, 2));
    endfunction

    // most addresses land on a handful of tags in the first few sets so that
    // hits, fills and evictions all happen; the rest are fully random
    function automatic logic [63:0] make_address();
        int sb, nways, shift;
        logic [63:0] tg, set_idx, offset, full;
        full = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            return full;
        sb = (cur_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cur_set_bits);
        nways = (cur_ways_used == 0) ? 1 :
                ((cur_ways_used > DEF_WAYS) ? DEF_WAYS : int'(cur_ways_used));
        shift = sb + int'(cur_block_bits);
        tg = 64'($urandom_range(0, 2 * nways + 1));
        set_idx = 64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1);
        offset = full & ((64'd1 << cur_block_bits) - 64'd1);
        return (tg << shift) | (set_idx << cur_block_bits) | offset;
    endfunction

    // one access transfer; valid stays up afterwards for the next one
    task automatic send_access(input func_t op, input logic [63:0] a);
        int gap;
        gap = idle_len(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        address  <= a;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (results_pending != 0);
        @(posedge clk);
    endtask

    // setup then access cycle; psel stays up so writes can go back to back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int p, n;
        func_t op;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on reset settings: 2 sets, 16-byte lines, 8 ways,
        // so the tag starts at bit 5
        send_access(FUNC_LOAD, 64'h0);                      // cold miss
        send_access(FUNC_LOAD, 64'h0);                      // hit
        send_access(FUNC_STORE, 64'hF);                     // same line, top offset
        send_access(FUNC_MODIFY, 64'h0);                    // modify hit scores two
        send_access(FUNC_MODIFY, 64'h20);                   // modify miss scores one
        send_access(FUNC_NONE, 64'hFFFF_FFFF_FFFF_FFFF);    // ignored code
        send_access(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);    // all address bits set
        send_access(FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        // overfill set 0 so the oldest lines get evicted
        for (n = 2; n <= 10; n++)
            send_access(FUNC_STORE, 64'(n) << 5);
        send_access(FUNC_LOAD, 64'h0);
        send_access(FUNC_NONE, 64'h0);
        send_access(FUNC_MODIFY, 64'h10);                   // set 1, tag 0

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                // registers change only with the block idle; earlier contents
                // stay, so a smaller ways_used meets sets that are already full
                drain_results();
                repeat (SETTLE_CYCLES) @(posedge clk);
                write_reg(REG_SET_BITS, 32'(PHASE_SET_BITS[p]));
                write_reg(REG_BLOCK_BITS, 32'(PHASE_BLOCK_BITS[p]));
                write_reg(REG_WAYS_USED, 32'(PHASE_WAYS_USED[p]));
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
                @(posedge clk);
                cur_set_bits   = PHASE_SET_BITS[p];
                cur_block_bits = PHASE_BLOCK_BITS[p];
                cur_ways_used  = PHASE_WAYS_USED[p];
            end
            // every third phase the sender runs without gaps
            sender_calm = (p % 3 == 2);
            n = 0;
            while (n < ACCESSES_PER_PHASE)
            begin
                op = random_func();
                send_access(op, make_address());
                if (op != FUNC_NONE)
                begin
                    n++;
                    accesses_sent++;
                    if (accesses_sent == PAUSE_AT_ACCESS)
                        drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (check_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, calm stretches, and one long block that
    // fills the pipe and pushes back on the access channel
    initial
    begin
        int gap, taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = (taken == STALL_AT_RESULT) ? STALL_HOLD_CYCLES : idle_len(calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
            taken++;
            if (taken % 150 == 0)
                calm = !calm;
        end
    end

    // timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/salc_pkg.sv
src/salc_row_mem.sv
src/salc_row_update.sv
src/salc_stats.sv
src/set_assoc_lru_cache_model.sv
dv/cache_access_checker.sv
dv/set_assoc_lru_cache_model_tb.sv
